### sv/camlb_pkg.sv
package camlb_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_KEY_SIZE   = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD_A = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD_B = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD_C = 3'd3;
   localparam logic [2:0] CSR_KEY_WORD_D = 3'd4;

   // key size codes
   localparam logic [1:0] KEY_128  = 2'd0;
   localparam logic [1:0] KEY_192  = 2'd1;
   localparam logic [1:0] KEY_256  = 2'd2;
   // spare code, behaves as a 256-bit key
   localparam logic [1:0] KEY_RSVD = 2'd3;

   // subkey counts and round counts
   localparam int NUM_SK_SHORT  = 26;
   localparam int NUM_SK_LONG   = 34;
   localparam int ROUNDS_SHORT  = 18;
   localparam int ROUNDS_LONG   = 24;
   localparam int SCHED_STEPS   = 6;

   // schedule source codes
   localparam logic [1:0] SRC_KL = 2'd0;
   localparam logic [1:0] SRC_KR = 2'd1;
   localparam logic [1:0] SRC_KA = 2'd2;
   localparam logic [1:0] SRC_KB = 2'd3;

   localparam logic [63:0] SIGMA [SCHED_STEPS] = '{
      64'hA09E667F3BCC908B, 64'hB67AE8584CAA73B2, 64'hC6EF372FE94F82BE,
      64'h54FF53A5F1D36F1C, 64'h10E527FADE682D1D, 64'hB05688C2B3E6C1FD
   };

   localparam logic [7:0] SBOX1 [256] = '{
      8'h70,8'h82,8'h2C,8'hEC,8'hB3,8'h27,8'hC0,8'hE5,8'hE4,8'h85,8'h57,8'h35,8'hEA,8'h0C,8'hAE,8'h41,
      8'h23,8'hEF,8'h6B,8'h93,8'h45,8'h19,8'hA5,8'h21,8'hED,8'h0E,8'h4F,8'h4E,8'h1D,8'h65,8'h92,8'hBD,
      8'h86,8'hB8,8'hAF,8'h8F,8'h7C,8'hEB,8'h1F,8'hCE,8'h3E,8'h30,8'hDC,8'h5F,8'h5E,8'hC5,8'h0B,8'h1A,
      8'hA6,8'hE1,8'h39,8'hCA,8'hD5,8'h47,8'h5D,8'h3D,8'hD9,8'h01,8'h5A,8'hD6,8'h51,8'h56,8'h6C,8'h4D,
      8'h8B,8'h0D,8'h9A,8'h66,8'hFB,8'hCC,8'hB0,8'h2D,8'h74,8'h12,8'h2B,8'h20,8'hF0,8'hB1,8'h84,8'h99,
      8'hDF,8'h4C,8'hCB,8'hC2,8'h34,8'h7E,8'h76,8'h05,8'h6D,8'hB7,8'hA9,8'h31,8'hD1,8'h17,8'h04,8'hD7,
      8'h14,8'h58,8'h3A,8'h61,8'hDE,8'h1B,8'h11,8'h1C,8'h32,8'h0F,8'h9C,8'h16,8'h53,8'h18,8'hF2,8'h22,
      8'hFE,8'h44,8'hCF,8'hB2,8'hC3,8'hB5,8'h7A,8'h91,8'h24,8'h08,8'hE8,8'hA8,8'h60,8'hFC,8'h69,8'h50,
      8'hAA,8'hD0,8'hA0,8'h7D,8'hA1,8'h89,8'h62,8'h97,8'h54,8'h5B,8'h1E,8'h95,8'hE0,8'hFF,8'h64,8'hD2,
      8'h10,8'hC4,8'h00,8'h48,8'hA3,8'hF7,8'h75,8'hDB,8'h8A,8'h03,8'hE6,8'hDA,8'h09,8'h3F,8'hDD,8'h94,
      8'h87,8'h5C,8'h83,8'h02,8'hCD,8'h4A,8'h90,8'h33,8'h73,8'h67,8'hF6,8'hF3,8'h9D,8'h7F,8'hBF,8'hE2,
      8'h52,8'h9B,8'hD8,8'h26,8'hC8,8'h37,8'hC6,8'h3B,8'h81,8'h96,8'h6F,8'h4B,8'h13,8'hBE,8'h63,8'h2E,
      8'hE9,8'h79,8'hA7,8'h8C,8'h9F,8'h6E,8'hBC,8'h8E,8'h29,8'hF5,8'hF9,8'hB6,8'h2F,8'hFD,8'hB4,8'h59,
      8'h78,8'h98,8'h06,8'h6A,8'hE7,8'h46,8'h71,8'hBA,8'hD4,8'h25,8'hAB,8'h42,8'h88,8'hA2,8'h8D,8'hFA,
      8'h72,8'h07,8'hB9,8'h55,8'hF8,8'hEE,8'hAC,8'h0A,8'h36,8'h49,8'h2A,8'h68,8'h3C,8'h38,8'hF1,8'hA4,
      8'h40,8'h28,8'hD3,8'h7B,8'hBB,8'hC9,8'h43,8'hC1,8'h15,8'hE3,8'hAD,8'hF4,8'h77,8'hC7,8'h80,8'h9E
   };

   // subkey entry: source, left rotation of the 128-bit source, low half select
   typedef struct packed {
      logic [1:0] src;
      logic [6:0] rot;
      logic       lo;
   } sched_entry_type;

   localparam sched_entry_type SCHED_SHORT [NUM_SK_SHORT] = '{
      '{SRC_KL,7'd0,1'b0},  '{SRC_KL,7'd0,1'b1},  '{SRC_KA,7'd0,1'b0},  '{SRC_KA,7'd0,1'b1},
      '{SRC_KL,7'd15,1'b0}, '{SRC_KL,7'd15,1'b1}, '{SRC_KA,7'd15,1'b0}, '{SRC_KA,7'd15,1'b1},
      '{SRC_KA,7'd30,1'b0}, '{SRC_KA,7'd30,1'b1}, '{SRC_KL,7'd45,1'b0}, '{SRC_KL,7'd45,1'b1},
      '{SRC_KA,7'd45,1'b0}, '{SRC_KL,7'd60,1'b1}, '{SRC_KA,7'd60,1'b0}, '{SRC_KA,7'd60,1'b1},
      '{SRC_KL,7'd77,1'b0}, '{SRC_KL,7'd77,1'b1}, '{SRC_KL,7'd94,1'b0}, '{SRC_KL,7'd94,1'b1},
      '{SRC_KA,7'd94,1'b0}, '{SRC_KA,7'd94,1'b1}, '{SRC_KL,7'd111,1'b0},'{SRC_KL,7'd111,1'b1},
      '{SRC_KA,7'd111,1'b0},'{SRC_KA,7'd111,1'b1}
   };

   localparam sched_entry_type SCHED_LONG [NUM_SK_LONG] = '{
      '{SRC_KL,7'd0,1'b0},  '{SRC_KL,7'd0,1'b1},  '{SRC_KB,7'd0,1'b0},  '{SRC_KB,7'd0,1'b1},
      '{SRC_KR,7'd15,1'b0}, '{SRC_KR,7'd15,1'b1}, '{SRC_KA,7'd15,1'b0}, '{SRC_KA,7'd15,1'b1},
      '{SRC_KR,7'd30,1'b0}, '{SRC_KR,7'd30,1'b1}, '{SRC_KB,7'd30,1'b0}, '{SRC_KB,7'd30,1'b1},
      '{SRC_KL,7'd45,1'b0}, '{SRC_KL,7'd45,1'b1}, '{SRC_KA,7'd45,1'b0}, '{SRC_KA,7'd45,1'b1},
      '{SRC_KL,7'd60,1'b0}, '{SRC_KL,7'd60,1'b1}, '{SRC_KR,7'd60,1'b0}, '{SRC_KR,7'd60,1'b1},
      '{SRC_KB,7'd60,1'b0}, '{SRC_KB,7'd60,1'b1}, '{SRC_KL,7'd77,1'b0}, '{SRC_KL,7'd77,1'b1},
      '{SRC_KA,7'd77,1'b0}, '{SRC_KA,7'd77,1'b1}, '{SRC_KR,7'd94,1'b0}, '{SRC_KR,7'd94,1'b1},
      '{SRC_KA,7'd94,1'b0}, '{SRC_KA,7'd94,1'b1}, '{SRC_KL,7'd111,1'b0},'{SRC_KL,7'd111,1'b1},
      '{SRC_KB,7'd111,1'b0},'{SRC_KB,7'd111,1'b1}
   };

   // half of a 128-bit value rotated left
   function automatic logic [63:0] rot_half(input logic [127:0] v, input logic [6:0] s,
                                            input logic lo);
      logic [127:0] r;
      r = (v << s) | (v >> (8'd128 - {1'b0, s}));
      return lo ? r[63:0] : r[127:64];
   endfunction

   // round function: key add, s-boxes, byte diffusion
   function automatic logic [63:0] f_func(input logic [63:0] v, input logic [63:0] k);
      logic [63:0] x;
      logic [7:0]  t1, t2, t3, t4, t5, t6, t7, t8, s2, s3, s5, s6;
      logic [7:0]  y0, y1, y2, y3, y4, y5, y6, y7;
      x  = v ^ k;
      t1 = SBOX1[x[63:56]];
      s2 = SBOX1[x[55:48]];
      s3 = SBOX1[x[47:40]];
      t4 = SBOX1[{x[38:32], x[39]}];
      s5 = SBOX1[x[31:24]];
      s6 = SBOX1[x[23:16]];
      t7 = SBOX1[{x[14:8], x[15]}];
      t8 = SBOX1[x[7:0]];
      t2 = {s2[6:0], s2[7]};
      t3 = {s3[0], s3[7:1]};
      t5 = {s5[6:0], s5[7]};
      t6 = {s6[0], s6[7:1]};
      y0 = t1 ^ t3 ^ t4 ^ t6 ^ t7 ^ t8;
      y1 = t1 ^ t2 ^ t4 ^ t5 ^ t7 ^ t8;
      y2 = t1 ^ t2 ^ t3 ^ t5 ^ t6 ^ t8;
      y3 = t2 ^ t3 ^ t4 ^ t5 ^ t6 ^ t7;
      y4 = t1 ^ t2 ^ t6 ^ t7 ^ t8;
      y5 = t2 ^ t3 ^ t5 ^ t7 ^ t8;
      y6 = t3 ^ t4 ^ t5 ^ t6 ^ t8;
      y7 = t1 ^ t4 ^ t5 ^ t6 ^ t7;
      return {y0, y1, y2, y3, y4, y5, y6, y7};
   endfunction

   function automatic logic [63:0] fl_func(input logic [63:0] v, input logic [63:0] k);
      logic [31:0] xl, xr, a;
      xl = v[63:32];
      xr = v[31:0];
      a  = xl & k[63:32];
      xr = xr ^ {a[30:0], a[31]};
      xl = xl ^ (xr | k[31:0]);
      return {xl, xr};
   endfunction

   function automatic logic [63:0] flinv_func(input logic [63:0] v, input logic [63:0] k);
      logic [31:0] xl, xr, a;
      xl = v[63:32];
      xr = v[31:0];
      xl = xl ^ (xr | k[31:0]);
      a  = xl & k[63:32];
      xr = xr ^ {a[30:0], a[31]};
      return {xl, xr};
   endfunction

endpackage

### sv/camlb_key_sched.sv
module camlb_key_sched (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output logic        keys_ready,
   output logic        long_key,
   output logic [63:0] sk_short [camlb_pkg::NUM_SK_SHORT],
   output logic [63:0] sk_long  [camlb_pkg::NUM_SK_LONG]
);

   logic [1:0]   key_size_ff;
   logic [63:0]  key_a_ff, key_b_ff, key_c_ff, key_d_ff;
   logic         stale_ff, running_ff;
   logic [2:0]   step_ff;
   logic [63:0]  d1_ff, d2_ff, d1_in, d2_in;
   logic [127:0] ka_ff, kb_ff;
   logic [127:0] kl, kr;
   logic [63:0]  f_out;
   logic [127:0] srcs [4];

   // key halves
   always_comb begin
      kl = {key_a_ff, key_b_ff};
      if (key_size_ff == camlb_pkg::KEY_128) begin
         kr = '0;
      end else if (key_size_ff == camlb_pkg::KEY_192) begin
         kr = {key_c_ff, ~key_c_ff};
      end else begin
         kr = {key_c_ff, key_d_ff};
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= '0;
         key_a_ff    <= '0;
         key_b_ff    <= '0;
         key_c_ff    <= '0;
         key_d_ff    <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            camlb_pkg::CSR_KEY_SIZE:   key_size_ff <= csr_data[1:0];
            camlb_pkg::CSR_KEY_WORD_A: key_a_ff    <= csr_data;
            camlb_pkg::CSR_KEY_WORD_B: key_b_ff    <= csr_data;
            camlb_pkg::CSR_KEY_WORD_C: key_c_ff    <= csr_data;
            camlb_pkg::CSR_KEY_WORD_D: key_d_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // one shared f unit, one step per cycle
   assign f_out = camlb_pkg::f_func(step_ff[0] ? d2_ff : d1_ff, camlb_pkg::SIGMA[step_ff]);

   always_comb begin
      d1_in = d1_ff;
      d2_in = d2_ff;
      if (step_ff[0]) begin
         d1_in = d1_ff ^ f_out;
      end else begin
         d2_in = d2_ff ^ f_out;
      end
      if (step_ff == 3'd1) begin
         d1_in = d1_in ^ kl[127:64];
         d2_in = d2_in ^ kl[63:0];
      end else if (step_ff == 3'd3) begin
         d1_in = d1_in ^ kr[127:64];
         d2_in = d2_in ^ kr[63:0];
      end
   end

   // schedule sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         stale_ff   <= 1'b1;
         running_ff <= 1'b0;
         step_ff    <= '0;
      end else if (csr_write_en && csr_index <= camlb_pkg::CSR_KEY_WORD_D) begin
         stale_ff   <= 1'b1;
         running_ff <= 1'b0;
      end else if (stale_ff) begin
         stale_ff   <= 1'b0;
         running_ff <= 1'b1;
         step_ff    <= '0;
      end else if (running_ff) begin
         step_ff <= step_ff + 3'd1;
         if (step_ff == 3'(camlb_pkg::SCHED_STEPS - 1)) begin
            running_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stale_ff) begin
         d1_ff <= kl[127:64] ^ kr[127:64];
         d2_ff <= kl[63:0] ^ kr[63:0];
      end else if (running_ff) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
         if (step_ff == 3'd3) begin
            ka_ff <= {d1_ff ^ f_out, d2_ff};
         end
         if (step_ff == 3'd5) begin
            kb_ff <= {d1_ff ^ f_out, d2_ff};
         end
      end
   end

   assign keys_ready = !stale_ff && !running_ff;
   assign long_key   = (key_size_ff != camlb_pkg::KEY_128);

   // subkeys are fixed rotations of the four sources
   assign srcs[camlb_pkg::SRC_KL] = kl;
   assign srcs[camlb_pkg::SRC_KR] = kr;
   assign srcs[camlb_pkg::SRC_KA] = ka_ff;
   assign srcs[camlb_pkg::SRC_KB] = kb_ff;

   for (genvar i = 0; i < camlb_pkg::NUM_SK_SHORT; i++) begin : g_short
      assign sk_short[i] = camlb_pkg::rot_half(srcs[camlb_pkg::SCHED_SHORT[i].src],
         camlb_pkg::SCHED_SHORT[i].rot, camlb_pkg::SCHED_SHORT[i].lo);
   end

   for (genvar i = 0; i < camlb_pkg::NUM_SK_LONG; i++) begin : g_long
      assign sk_long[i] = camlb_pkg::rot_half(srcs[camlb_pkg::SCHED_LONG[i].src],
         camlb_pkg::SCHED_LONG[i].rot, camlb_pkg::SCHED_LONG[i].lo);
   end

endmodule

### sv/camellia_block_cipher.sv
// stages from input transfer to result: whitening, 24 round stages, output register
// throughput: one block per cycle unless stalled; a 128-bit key passes the last six
// round stages unchanged; after reset or a key register write the subkey schedule
// runs through one shared f unit, and req_stall stays high until it is done
// reset is synchronous: clears all valid bits and the key registers, schedule marked stale
module camellia_block_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int NS  = camlb_pkg::ROUNDS_LONG + 1;
   localparam int NSS = camlb_pkg::NUM_SK_SHORT;
   localparam int NSL = camlb_pkg::NUM_SK_LONG;

   logic        keys_ready, long_key;
   logic [63:0] sk_short [NSS];
   logic [63:0] sk_long  [NSL];

   logic        vld_ff [NS];
   logic        op_ff  [NS];
   logic [63:0] d1_ff  [NS];
   logic [63:0] d2_ff  [NS];
   logic [63:0] d1_in  [NS];
   logic [63:0] d2_in  [NS];
   logic        en     [NS];
   logic        en_out, accept;
   logic        rsp_valid_ff;
   logic [63:0] rsp_high_ff, rsp_low_ff;
   logic [63:0] kw0, kw1, kf0, kf1;

   camlb_key_sched u_sched (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .keys_ready   (keys_ready),
      .long_key     (long_key),
      .sk_short     (sk_short),
      .sk_long      (sk_long)
   );

   // stage enables: a stage moves when empty or when the next one moves
   assign en_out = !rsp_valid_ff || !rsp_stall;
   assign en[NS-1] = !vld_ff[NS-1] || en_out;
   for (genvar s = 0; s < NS - 1; s++) begin : g_en
      assign en[s] = !vld_ff[s] || en[s+1];
   end

   assign req_stall = !keys_ready || !en[0];
   assign accept    = req_valid && !req_stall;

   // input whitening keys
   always_comb begin
      if (!req_operation) begin
         kw0 = long_key ? sk_long[0] : sk_short[0];
         kw1 = long_key ? sk_long[1] : sk_short[1];
      end else begin
         kw0 = long_key ? sk_long[NSL-2] : sk_short[NSS-2];
         kw1 = long_key ? sk_long[NSL-1] : sk_short[NSS-1];
      end
   end

   assign d1_in[0] = req_block_high ^ kw0;
   assign d2_in[0] = req_block_low ^ kw1;

   // round stages
   for (genvar j = 0; j < camlb_pkg::ROUNDS_LONG; j++) begin : g_round
      localparam int G  = j / 6;
      localparam int R  = j % 6;
      localparam int KI = 2 + 8 * G + R;
      localparam int FI = 2 + 8 * G + 6;
      logic [63:0] rk, fk0, fk1;
      logic [63:0] a, b;

      if (j < camlb_pkg::ROUNDS_SHORT) begin : g_both
         always_comb begin
            if (long_key) begin
               rk = op_ff[j] ? sk_long[NSL-1-KI] : sk_long[KI];
            end else begin
               rk = op_ff[j] ? sk_short[NSS-1-KI] : sk_short[KI];
            end
         end
      end else begin : g_long_only
         assign rk = op_ff[j] ? sk_long[NSL-1-KI] : sk_long[KI];
      end

      if (R == 5 && G < 2) begin : g_fl_both
         always_comb begin
            if (long_key) begin
               fk0 = op_ff[j] ? sk_long[NSL-1-FI] : sk_long[FI];
               fk1 = op_ff[j] ? sk_long[NSL-2-FI] : sk_long[FI+1];
            end else begin
               fk0 = op_ff[j] ? sk_short[NSS-1-FI] : sk_short[FI];
               fk1 = op_ff[j] ? sk_short[NSS-2-FI] : sk_short[FI+1];
            end
         end
      end else if (R == 5 && G == 2) begin : g_fl_long
         assign fk0 = op_ff[j] ? sk_long[NSL-1-FI] : sk_long[FI];
         assign fk1 = op_ff[j] ? sk_long[NSL-2-FI] : sk_long[FI+1];
      end else begin : g_no_fl
         assign fk0 = '0;
         assign fk1 = '0;
      end

      always_comb begin
         a = d1_ff[j];
         b = d2_ff[j];
         if (long_key || j < camlb_pkg::ROUNDS_SHORT) begin
            if (R % 2 == 0) begin
               b = b ^ camlb_pkg::f_func(a, rk);
            end else begin
               a = a ^ camlb_pkg::f_func(b, rk);
            end
         end
         if (R == 5 && (G < 2 || (G == 2 && long_key))) begin
            a = camlb_pkg::fl_func(a, fk0);
            b = camlb_pkg::flinv_func(b, fk1);
         end
         d1_in[j+1] = a;
         d2_in[j+1] = b;
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         if (en[0]) begin
            vld_ff[0] <= accept;
         end
         for (int s = 1; s < NS; s++) begin
            if (en[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (en[0]) begin
         op_ff[0] <= req_operation;
         d1_ff[0] <= d1_in[0];
         d2_ff[0] <= d2_in[0];
      end
      for (int s = 1; s < NS; s++) begin
         if (en[s]) begin
            op_ff[s] <= op_ff[s-1];
            d1_ff[s] <= d1_in[s];
            d2_ff[s] <= d2_in[s];
         end
      end
   end

   // output whitening keys
   always_comb begin
      if (!op_ff[NS-1]) begin
         kf0 = long_key ? sk_long[NSL-2] : sk_short[NSS-2];
         kf1 = long_key ? sk_long[NSL-1] : sk_short[NSS-1];
      end else begin
         kf0 = long_key ? sk_long[0] : sk_short[0];
         kf1 = long_key ? sk_long[1] : sk_short[1];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_high_ff <= d2_ff[NS-1] ^ kf0;
         rsp_low_ff  <= d1_ff[NS-1] ^ kf1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_high = rsp_high_ff;
   assign rsp_result_low  = rsp_low_ff;

endmodule

### sim/camellia_checker.sv
module camellia_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_operation,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_result_high,
   input  logic [63:0] rsp_result_low,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          fail_count,
   output int          blocks_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
   } cipher_block_type;

   // shadow key registers and subkeys
   logic [1:0]  key_size_q;
   logic [63:0] key_a, key_b, key_c, key_d;
   logic [63:0] subkeys [camlb_pkg::NUM_SK_LONG];
   int          subkey_count;
   bit          schedule_fresh;
   cipher_block_type expected_blocks [$];

   // round function
   function automatic logic [63:0] feistel_f(logic [63:0] v, logic [63:0] k);
      logic [63:0] x;
      logic [7:0] b [8];
      logic [7:0] t [8];
      logic [7:0] s;
      x = v ^ k;
      for (int i = 0; i < 8; i++) b[i] = x[63 - 8 * i -: 8];
      t[0] = camlb_pkg::SBOX1[b[0]];
      s = camlb_pkg::SBOX1[b[1]]; t[1] = {s[6:0], s[7]};
      s = camlb_pkg::SBOX1[b[2]]; t[2] = {s[0], s[7:1]};
      t[3] = camlb_pkg::SBOX1[{b[3][6:0], b[3][7]}];
      s = camlb_pkg::SBOX1[b[4]]; t[4] = {s[6:0], s[7]};
      s = camlb_pkg::SBOX1[b[5]]; t[5] = {s[0], s[7:1]};
      t[6] = camlb_pkg::SBOX1[{b[6][6:0], b[6][7]}];
      t[7] = camlb_pkg::SBOX1[b[7]];
      return {t[0] ^ t[2] ^ t[3] ^ t[5] ^ t[6] ^ t[7],
              t[0] ^ t[1] ^ t[3] ^ t[4] ^ t[6] ^ t[7],
              t[0] ^ t[1] ^ t[2] ^ t[4] ^ t[5] ^ t[7],
              t[1] ^ t[2] ^ t[3] ^ t[4] ^ t[5] ^ t[6],
              t[0] ^ t[1] ^ t[5] ^ t[6] ^ t[7],
              t[1] ^ t[2] ^ t[4] ^ t[6] ^ t[7],
              t[2] ^ t[3] ^ t[4] ^ t[5] ^ t[7],
              t[0] ^ t[3] ^ t[4] ^ t[5] ^ t[6]};
   endfunction

   function automatic logic [63:0] rotl1_pair(logic [63:0] v, logic [63:0] k, bit inverse);
      logic [31:0] l, r, a;
      l = v[63:32];
      r = v[31:0];
      if (!inverse) begin
         a = l & k[63:32];
         r ^= {a[30:0], a[31]};
         l ^= r | k[31:0];
      end else begin
         l ^= r | k[31:0];
         a = l & k[63:32];
         r ^= {a[30:0], a[31]};
      end
      return {l, r};
   endfunction

   // key schedule from the shadow registers
   task automatic expand_key();
      logic [127:0] kl, kr, ka, kb, srcv;
      logic [63:0]  d1, d2;
      logic [127:0] rot;
      logic [1:0]   sel;
      logic [6:0]   amount;
      logic         half;
      kl = {key_a, key_b};
      if (key_size_q == camlb_pkg::KEY_128) kr = '0;
      else if (key_size_q == camlb_pkg::KEY_192) kr = {key_c, ~key_c};
      else kr = {key_c, key_d};
      d1 = kl[127:64] ^ kr[127:64];
      d2 = kl[63:0] ^ kr[63:0];
      d2 ^= feistel_f(d1, 64'hA09E667F3BCC908B);
      d1 ^= feistel_f(d2, 64'hB67AE8584CAA73B2);
      d1 ^= kl[127:64];
      d2 ^= kl[63:0];
      d2 ^= feistel_f(d1, 64'hC6EF372FE94F82BE);
      d1 ^= feistel_f(d2, 64'h54FF53A5F1D36F1C);
      ka = {d1, d2};
      d1 ^= kr[127:64];
      d2 ^= kr[63:0];
      d2 ^= feistel_f(d1, 64'h10E527FADE682D1D);
      d1 ^= feistel_f(d2, 64'hB05688C2B3E6C1FD);
      kb = {d1, d2};
      subkey_count = (key_size_q == camlb_pkg::KEY_128) ? camlb_pkg::NUM_SK_SHORT
                                                         : camlb_pkg::NUM_SK_LONG;
      for (int i = 0; i < subkey_count; i++) begin
         if (subkey_count == camlb_pkg::NUM_SK_SHORT) begin
            sel = camlb_pkg::SCHED_SHORT[i].src; amount = camlb_pkg::SCHED_SHORT[i].rot;
            half = camlb_pkg::SCHED_SHORT[i].lo;
         end else begin
            sel = camlb_pkg::SCHED_LONG[i].src; amount = camlb_pkg::SCHED_LONG[i].rot;
            half = camlb_pkg::SCHED_LONG[i].lo;
         end
         case (sel)
            camlb_pkg::SRC_KL: srcv = kl;
            camlb_pkg::SRC_KR: srcv = kr;
            camlb_pkg::SRC_KA: srcv = ka;
            default: srcv = kb;
         endcase
         rot = (amount == 7'd0) ? srcv : ((srcv << amount) | (srcv >> (128 - amount)));
         subkeys[i] = half ? rot[63:0] : rot[127:64];
      end
      schedule_fresh = 1;
   endtask

   function automatic cipher_block_type transform_block(bit decrypt, logic [63:0] hi,
                                                        logic [63:0] lo);
      logic [63:0] k [camlb_pkg::NUM_SK_LONG];
      logic [63:0] d1, d2;
      int n, groups, base;
      cipher_block_type res;
      n = subkey_count;
      if (!decrypt) begin
         for (int i = 0; i < n; i++) k[i] = subkeys[i];
      end else begin
         k[0] = subkeys[n - 2];
         k[1] = subkeys[n - 1];
         for (int i = 2; i <= n - 3; i++) k[i] = subkeys[n - 1 - i];
         k[n - 2] = subkeys[0];
         k[n - 1] = subkeys[1];
      end
      groups = (n == camlb_pkg::NUM_SK_SHORT) ? 3 : 4;
      d1 = hi ^ k[0];
      d2 = lo ^ k[1];
      for (int g = 0; g < groups; g++) begin
         base = 2 + 8 * g;
         for (int r = 0; r < 6; r += 2) begin
            d2 ^= feistel_f(d1, k[base + r]);
            d1 ^= feistel_f(d2, k[base + r + 1]);
         end
         if (g + 1 < groups) begin
            d1 = rotl1_pair(d1, k[base + 6], 0);
            d2 = rotl1_pair(d2, k[base + 7], 1);
         end
      end
      res.hi = d2 ^ k[n - 2];
      res.lo = d1 ^ k[n - 1];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // watch csr writes, input and result transfers
   always @(posedge clock) begin
      cipher_block_type want;
      if (reset) begin
         key_size_q <= '0;
         key_a <= '0; key_b <= '0; key_c <= '0; key_d <= '0;
         schedule_fresh = 0;
         subkey_count = camlb_pkg::NUM_SK_SHORT;
         fail_count = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               camlb_pkg::CSR_KEY_SIZE:   key_size_q <= csr_data[1:0];
               camlb_pkg::CSR_KEY_WORD_A: key_a <= csr_data;
               camlb_pkg::CSR_KEY_WORD_B: key_b <= csr_data;
               camlb_pkg::CSR_KEY_WORD_C: key_c <= csr_data;
               camlb_pkg::CSR_KEY_WORD_D: key_d <= csr_data;
               default: ;
            endcase
            if (csr_index <= camlb_pkg::CSR_KEY_WORD_D) schedule_fresh = 0;
         end
         if (req_valid && !req_stall) begin
            if (!schedule_fresh) expand_key();
            expected_blocks.push_back(transform_block(req_operation, req_block_high,
                                                      req_block_low));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_blocks.size() == 0) begin
               $display("unexpected result transfer %h %h at %0t", rsp_result_high,
                        rsp_result_low, $realtime);
               fail_count++;
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_result_high !== want.hi)
                  report_mismatch("result_high", rsp_result_high, want.hi);
               if (rsp_result_low !== want.lo)
                  report_mismatch("result_low", rsp_result_low, want.lo);
            end
         end
      end
      blocks_pending = expected_blocks.size();
   end

endmodule

### sim/tb_camellia_block_cipher.sv
module tb_camellia_block_cipher;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_operation = 0;
   logic [63:0] req_block_high = '0;
   logic [63:0] req_block_low = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [63:0] rsp_result_high, rsp_result_low;
   logic        csr_write_en = 0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   int          fail_count, blocks_pending;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off_req = 0;
   bit hold_off_done = 0;

   camellia_block_cipher dut (.*);
   camellia_checker u_checker (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // receiver stall, with one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_off_done) begin
            rsp_stall <= 1;
            repeat (200) @(posedge clock);
            hold_off_done = 1;
            rsp_stall <= 0;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // drives one write; the caller drops the write enable after the last one
   task automatic write_csr(logic [2:0] idx, logic [63:0] value);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
   endtask

   // wait for the pipeline to drain before touching the keys
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (blocks_pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic load_key(logic [1:0] size, logic [63:0] a, logic [63:0] b,
                           logic [63:0] c, logic [63:0] d);
      drain();
      write_csr(camlb_pkg::CSR_KEY_SIZE, {62'd0, size});
      write_csr(camlb_pkg::CSR_KEY_WORD_A, a);
      write_csr(camlb_pkg::CSR_KEY_WORD_B, b);
      write_csr(camlb_pkg::CSR_KEY_WORD_C, c);
      write_csr(camlb_pkg::CSR_KEY_WORD_D, d);
      csr_write_en <= 0;
   endtask

   // one input transfer, valid held through stalls and left high afterwards
   task automatic send_block(bit op, logic [63:0] hi, logic [63:0] lo);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_operation <= op;
      req_block_high <= hi;
      req_block_low <= lo;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random(int count);
      logic [63:0] hi, lo;
      for (int i = 0; i < count; i++) begin
         hi = rand64();
         lo = rand64();
         case ($urandom_range(7))
            0: hi = '0;
            1: lo = '1;
            default: ;
         endcase
         send_block(1'($urandom_range(1)), hi, lo);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: default zero key, then the RFC vectors and extremes
      send_block(0, '0, '0);
      send_block(1, '1, '1);
      load_key(camlb_pkg::KEY_128, 64'h0123456789abcdef, 64'hfedcba9876543210, '1, '1);
      send_block(0, 64'h0123456789abcdef, 64'hfedcba9876543210);
      send_block(1, 64'h6767313854966973, 64'h0857065648eabe43);
      send_block(0, '1, '0);
      send_block(1, '0, '1);
      load_key(camlb_pkg::KEY_192, 64'h0123456789abcdef, 64'hfedcba9876543210,
               64'h0011223344556677, 64'h1234);
      send_block(0, 64'h0123456789abcdef, 64'hfedcba9876543210);
      send_block(1, '1, '1);
      load_key(camlb_pkg::KEY_256, 64'h0123456789abcdef, 64'hfedcba9876543210,
               64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(0, 64'h0123456789abcdef, 64'hfedcba9876543210);
      send_block(1, '0, '0);
      // unused size code behaves as 256 bits
      load_key(camlb_pkg::KEY_RSVD, '1, '1, '1, '1);
      send_block(0, '1, '1);
      send_block(1, '0, '1);
      load_key(camlb_pkg::KEY_256, '0, '0, '0, '0);
      send_block(0, '0, '0);
      // out of range index is ignored
      drain();
      write_csr(3'd5, '1);
      write_csr(3'd7, '1);
      csr_write_en <= 0;
      send_block(1, '1, '0);

      // random phases over key sizes and idle mixes
      for (int phase = 0; phase < 12; phase++) begin
         case (phase / 4)
            0: begin send_idle_pct = 34; recv_idle_pct = 78; end
            1: begin send_idle_pct = 78; recv_idle_pct = 34; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         load_key(2'(phase % 4), rand64(), rand64(), rand64(), rand64());
         if (phase == 2) hold_off_req = 1;
         send_random(45);
         // sender pauses until every result is back
         req_valid <= 0;
         @(posedge clock);
         while (blocks_pending != 0) @(posedge clock);
         send_random(45);
      end

      drain();
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
